FILE: sv/depth_tested_char_framebuffer_unit_assert.svh
// assertion macros shared by the framebuffer controller and datapath
// no dependencies; included by dtcf_ctrl and dtcf_datapath
`ifndef DEPTH_TESTED_CHAR_FRAMEBUFFER_UNIT_ASSERT_SVH
`define DEPTH_TESTED_CHAR_FRAMEBUFFER_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define DTCF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define DTCF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: sv/dtcf_pkg.sv
// shared types and constants of the depth tested character framebuffer
// no dependencies; used by dtcf_ctrl, dtcf_datapath and the top level
`default_nettype none

package dtcf_pkg;

   localparam int MAX_WIDTH  = 128;
   localparam int MAX_HEIGHT = 64;
   localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   localparam logic [7:0]  BLANK_SYMBOL = 8'd32;
   localparam logic [15:0] BLANK_DEPTH  = 16'd0;
   localparam logic [7:0]  WIDTH_CAP    = 8'(MAX_WIDTH);
   localparam logic [6:0]  HEIGHT_CAP   = 7'(MAX_HEIGHT);

   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_SET   = 2'd1,
      OP_GET   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_ORIGIN_X      = 2'd0,
      CSR_ORIGIN_Y      = 2'd1,
      CSR_ACTIVE_WIDTH  = 2'd2,
      CSR_ACTIVE_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_WIPE,
      ST_IDLE,
      ST_RESOLVE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic wipe_step;
      logic resolve;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_clear;
      logic wipe_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: sv/depth_tested_char_framebuffer_unit.sv
// Character framebuffer with a per-cell depth store (z-buffer depth test), 128 x 64 cells.
// A set or get request forms the cell address and reads the cell memory on the accept edge; the
// depth test, write-back and response load happen in the resolve state once the output register
// is free (one write port, registered read). A clear request sweeps the memory one cell per
// cycle, all 8192 cells, then returns its response; after reset the same clearing pass runs
// with req_tready low. Results sit in an output register, so a waiting response only holds
// off the next request's resolve step. Configuration writes are taken at any time.
// Depends on dtcf_pkg, dtcf_ctrl and dtcf_datapath.
`default_nettype none

module depth_tested_char_framebuffer_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // x_pos[9:0], y_pos[19:10], depth[35:20], symbol[43:36], zero fill[47:44]
   input  wire logic [dtcf_pkg::REQ_DATA_W-1:0]    req_tdata,
   // operation[1:0]
   input  wire logic [dtcf_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // read_symbol[7:0], written[8], in_field[9], zero fill[15:10]
   output logic [dtcf_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [dtcf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dtcf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   dtcf_pkg::cmd_type    cmd;
   dtcf_pkg::status_type status;

   dtcf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dtcf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

FILE: sv/dtcf_datapath.sv
// datapath: config registers, field locate, cell memory, depth test, response register
// depends on dtcf_pkg and depth_tested_char_framebuffer_unit_assert.svh
`default_nettype none
`include "depth_tested_char_framebuffer_unit_assert.svh"

module dtcf_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [dtcf_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic [dtcf_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [dtcf_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [dtcf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dtcf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire dtcf_pkg::cmd_type                  cmd,
   output dtcf_pkg::status_type                    status
);

   // configuration
   logic signed [8:0] origin_x_ff;
   logic signed [8:0] origin_y_ff;
   logic [7:0]        active_width_ff;
   logic [6:0]        active_height_ff;

   // request fields
   logic signed [9:0]  x_pos;
   logic signed [9:0]  y_pos;
   logic [15:0]        req_depth;
   logic [7:0]         req_symbol;

   logic signed [10:0] col;
   logic signed [10:0] row;
   logic [7:0]         width_eff;
   logic [6:0]         height_eff;
   logic               in_field;
   logic [dtcf_pkg::ADDR_W-1:0] rd_addr;

   // captured request
   logic [1:0]                  op_ff;
   logic                        in_field_ff;
   logic [dtcf_pkg::ADDR_W-1:0] addr_ff;
   logic [15:0]                 depth_ff;
   logic [7:0]                  symbol_ff;

   // cell memory: depth in the upper bits, symbol in the lower
   logic [23:0] cell_mem [dtcf_pkg::CELL_COUNT];
   logic [23:0] rdata_ff;
   logic [dtcf_pkg::ADDR_W-1:0] wipe_cnt_ff;
   logic [dtcf_pkg::ADDR_W-1:0] wipe_cnt_in;

   logic signed [15:0] new_depth;
   logic signed [15:0] old_depth;
   logic               depth_pass;
   logic               set_we;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_symbol_ff;
   logic       rsp_written_ff;
   logic       rsp_in_field_ff;
   logic [7:0] res_symbol;
   logic       res_written;
   logic       res_in_field;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         active_width_ff  <= 8'd128;
         active_height_ff <= 7'd64;
      end else if (csr_we) begin
         case (csr_index)
            dtcf_pkg::CSR_ORIGIN_X:      origin_x_ff      <= csr_wdata;
            dtcf_pkg::CSR_ORIGIN_Y:      origin_y_ff      <= csr_wdata;
            dtcf_pkg::CSR_ACTIVE_WIDTH:  active_width_ff  <= csr_wdata[7:0];
            dtcf_pkg::CSR_ACTIVE_HEIGHT: active_height_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   assign x_pos      = req_tdata[9:0];
   assign y_pos      = req_tdata[19:10];
   assign req_depth  = req_tdata[35:20];
   assign req_symbol = req_tdata[43:36];

   assign width_eff  = (active_width_ff > dtcf_pkg::WIDTH_CAP) ?
                       dtcf_pkg::WIDTH_CAP : active_width_ff;
   assign height_eff = (active_height_ff > dtcf_pkg::HEIGHT_CAP) ?
                       dtcf_pkg::HEIGHT_CAP : active_height_ff;

   assign col = 11'(x_pos) + 11'(origin_x_ff);
   assign row = 11'(y_pos) + 11'(origin_y_ff);

   assign in_field = !col[10] && !row[10] &&
                     (col[9:0] < {2'b00, width_eff}) &&
                     (row[9:0] < {3'b000, height_eff});

   assign rd_addr = dtcf_pkg::ADDR_W'(row[dtcf_pkg::ROW_W-1:0]) *
                    dtcf_pkg::ADDR_W'(dtcf_pkg::MAX_WIDTH) +
                    dtcf_pkg::ADDR_W'(col[dtcf_pkg::COL_W-1:0]);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= req_tuser;
         in_field_ff <= in_field;
         addr_ff     <= rd_addr;
         depth_ff    <= req_depth;
         symbol_ff   <= req_symbol;
      end
   end

   // wipe counter wraps back to zero after the last cell
   assign wipe_cnt_in = cmd.wipe_step ? wipe_cnt_ff + 1'b1 : wipe_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wipe_cnt_ff <= '0;
      end else begin
         wipe_cnt_ff <= wipe_cnt_in;
      end
   end

   assign new_depth  = depth_ff;
   assign old_depth  = rdata_ff[23:8];
   assign depth_pass = (new_depth > 16'sd0) &&
                       ((old_depth <= 16'sd0) || (new_depth <= old_depth));
   assign set_we     = cmd.resolve && (op_ff == dtcf_pkg::OP_SET) &&
                       in_field_ff && depth_pass;

   always_ff @(posedge clock) begin
      if (cmd.wipe_step) begin
         cell_mem[wipe_cnt_ff] <= {dtcf_pkg::BLANK_DEPTH, dtcf_pkg::BLANK_SYMBOL};
      end else if (set_we) begin
         cell_mem[addr_ff] <= {depth_ff, symbol_ff};
      end
      if (cmd.accept) begin
         rdata_ff <= cell_mem[rd_addr];
      end
   end

   always_comb begin
      res_symbol   = '0;
      res_written  = 1'b0;
      res_in_field = 1'b0;
      case (op_ff)
         dtcf_pkg::OP_SET: begin
            res_written  = in_field_ff && depth_pass;
            res_in_field = in_field_ff;
         end
         dtcf_pkg::OP_GET: begin
            res_symbol   = in_field_ff ? rdata_ff[7:0] : 8'd0;
            res_in_field = in_field_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.resolve) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         rsp_symbol_ff   <= res_symbol;
         rsp_written_ff  <= res_written;
         rsp_in_field_ff <= res_in_field;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_in_field_ff, rsp_written_ff, rsp_symbol_ff};

   assign status.req_clear = (req_tuser == dtcf_pkg::OP_CLEAR);
   assign status.wipe_last = (wipe_cnt_ff == dtcf_pkg::ADDR_W'(dtcf_pkg::CELL_COUNT - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   `DTCF_ASSERT(a_set_we_slot_free, set_we |-> (!rsp_valid_ff || rsp_tready),
      "cell written while response slot was still occupied")
   `DTCF_ASSERT(a_resolve_loads, cmd.resolve |=> rsp_valid_ff,
      "resolved request did not produce a response")
   `DTCF_ASSERT(a_written_in_field,
      (cmd.resolve && res_written) |-> (res_in_field && op_ff == dtcf_pkg::OP_SET),
      "write reported outside the active field")

endmodule

`default_nettype wire

FILE: sv/dtcf_ctrl.sv
// controller: sequences wipe sweeps, request acceptance and response handoff
// depends on dtcf_pkg and depth_tested_char_framebuffer_unit_assert.svh
`default_nettype none
`include "depth_tested_char_framebuffer_unit_assert.svh"

module dtcf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire dtcf_pkg::status_type  status,
   output dtcf_pkg::cmd_type          cmd
);

   dtcf_pkg::state_type state_ff;
   dtcf_pkg::state_type state_in;
   logic                rsp_pending_ff;
   logic                rsp_pending_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtcf_pkg::ST_WIPE: begin
            if (status.wipe_last) begin
               state_in = rsp_pending_ff ? dtcf_pkg::ST_RESOLVE : dtcf_pkg::ST_IDLE;
            end
         end
         dtcf_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = status.req_clear ? dtcf_pkg::ST_WIPE : dtcf_pkg::ST_RESOLVE;
            end
         end
         dtcf_pkg::ST_RESOLVE: begin
            if (status.out_free) begin
               state_in = dtcf_pkg::ST_IDLE;
            end
         end
         default: state_in = dtcf_pkg::ST_IDLE;
      endcase
   end

   // a wipe started by a clear request owes a response, one after reset does not
   always_comb begin
      rsp_pending_in = rsp_pending_ff;
      if (state_ff == dtcf_pkg::ST_IDLE && req_tvalid && status.req_clear) begin
         rsp_pending_in = 1'b1;
      end else if (state_ff == dtcf_pkg::ST_WIPE && status.wipe_last) begin
         rsp_pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dtcf_pkg::ST_WIPE;
         rsp_pending_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_pending_ff <= rsp_pending_in;
      end
   end

   always_comb begin
      req_tready    = 1'b0;
      cmd.accept    = 1'b0;
      cmd.wipe_step = 1'b0;
      cmd.resolve   = 1'b0;
      case (state_ff)
         dtcf_pkg::ST_WIPE: begin
            cmd.wipe_step = 1'b1;
         end
         dtcf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         dtcf_pkg::ST_RESOLVE: begin
            cmd.resolve = status.out_free;
         end
         default: ;
      endcase
   end

   `DTCF_ASSERT(a_pending_only_in_wipe, rsp_pending_ff |-> (state_ff == dtcf_pkg::ST_WIPE),
      "response pending outside a wipe sweep")
   `DTCF_ASSERT(a_clear_wipe_resolves,
      (state_ff == dtcf_pkg::ST_WIPE && status.wipe_last && rsp_pending_ff)
         |=> (state_ff == dtcf_pkg::ST_RESOLVE),
      "clear sweep ended without a response")
   `DTCF_ASSERT(a_cell_op_resolves,
      (req_tvalid && req_tready && !status.req_clear) |=> (state_ff == dtcf_pkg::ST_RESOLVE),
      "accepted cell request did not move to resolve")

endmodule

`default_nettype wire

FILE: bench/tb_depth_tested_char_framebuffer_unit.sv
`timescale 1ns / 1ps
// testbench for the depth tested character framebuffer: set, get and clear requests, with a
// scoreboard that keeps its own symbol and depth stores, random idling and field settings
// depends on dtcf_pkg and depth_tested_char_framebuffer_unit

module tb_depth_tested_char_framebuffer_unit;

   localparam logic [1:0] OP_UNUSED      = 2'd3;
   localparam int         WATCHDOG_LIMIT = 40000;

   typedef struct {
      logic [1:0]         op_code;
      logic signed [9:0]  x_pos;
      logic signed [9:0]  y_pos;
      logic signed [15:0] depth;
      logic [7:0]         symbol;
   } fb_request_type;

   typedef struct {
      logic [7:0] read_symbol;
      logic       written;
      logic       in_field;
   } fb_result_type;

   class cell_scoreboard;
      logic [7:0]         symbol_mem [dtcf_pkg::CELL_COUNT];
      logic signed [15:0] depth_mem [dtcf_pkg::CELL_COUNT];
      int                 origin_x;
      int                 origin_y;
      int                 active_w;
      int                 active_h;
      fb_result_type      expected_rsp [$];
      int                 error_count;

      function new();
         wipe_cells();
         origin_x    = 0;
         origin_y    = 0;
         active_w    = 128;
         active_h    = 64;
         error_count = 0;
      endfunction

      function void wipe_cells();
         for (int i = 0; i < dtcf_pkg::CELL_COUNT; i++) begin
            symbol_mem[i] = dtcf_pkg::BLANK_SYMBOL;
            depth_mem[i]  = '0;
         end
      endfunction

      function void write_register(dtcf_pkg::csr_index_type idx, logic [8:0] value);
         case (idx)
            dtcf_pkg::CSR_ORIGIN_X:      origin_x = int'($signed(value));
            dtcf_pkg::CSR_ORIGIN_Y:      origin_y = int'($signed(value));
            dtcf_pkg::CSR_ACTIVE_WIDTH:  active_w = int'(value[7:0]);
            dtcf_pkg::CSR_ACTIVE_HEIGHT: active_h = int'(value[6:0]);
            default: ;
         endcase
      endfunction

      // offset the point and find its cell; active size saturates at the store size
      function bit locate_cell(fb_request_type r, output int addr);
         int col, row, w, h;
         col  = int'(r.x_pos) + origin_x;
         row  = int'(r.y_pos) + origin_y;
         w    = (active_w > dtcf_pkg::MAX_WIDTH) ? dtcf_pkg::MAX_WIDTH : active_w;
         h    = (active_h > dtcf_pkg::MAX_HEIGHT) ? dtcf_pkg::MAX_HEIGHT : active_h;
         addr = col + row * dtcf_pkg::MAX_WIDTH;
         return (col >= 0 && row >= 0 && col < w && row < h);
      endfunction

      function fb_result_type resolve_access(fb_request_type r);
         fb_result_type res;
         int            addr;
         res = '{read_symbol: 8'd0, written: 1'b0, in_field: 1'b0};
         case (r.op_code)
            dtcf_pkg::OP_CLEAR: wipe_cells();
            dtcf_pkg::OP_SET: begin
               if (locate_cell(r, addr)) begin
                  res.in_field = 1'b1;
                  // positive new depth, and an empty cell or a new symbol at the same depth or nearer
                  if (r.depth > 0 && (depth_mem[addr] <= 0 || r.depth <= depth_mem[addr])) begin
                     symbol_mem[addr] = r.symbol;
                     depth_mem[addr]  = r.depth;
                     res.written      = 1'b1;
                  end
               end
            end
            dtcf_pkg::OP_GET: begin
               if (locate_cell(r, addr)) begin
                  res.in_field    = 1'b1;
                  res.read_symbol = symbol_mem[addr];
               end
            end
            default: ;
         endcase
         return res;
      endfunction

      function void note_request(fb_request_type r);
         expected_rsp.push_back(resolve_access(r));
      endfunction

      function void check_response(logic [dtcf_pkg::RSP_DATA_W-1:0] data);
         fb_result_type want;
         if (expected_rsp.size() == 0) begin
            $error("response with no request outstanding: data %h", data);
            error_count++;
            return;
         end
         want = expected_rsp.pop_front();
         if (data[7:0] !== want.read_symbol) begin
            $error("read_symbol mismatch: expected %0d, actual %0d", want.read_symbol, data[7:0]);
            error_count++;
         end
         if (data[8] !== want.written) begin
            $error("written mismatch: expected %0d, actual %0d", want.written, data[8]);
            error_count++;
         end
         if (data[9] !== want.in_field) begin
            $error("in_field mismatch: expected %0d, actual %0d", want.in_field, data[9]);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [dtcf_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [dtcf_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [dtcf_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_we = 1'b0;
   logic [dtcf_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [dtcf_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   cell_scoreboard board = new();
   int             send_idle_pct = 0;
   int             rsp_stall_pct = 0;
   int             field_ox = 0;
   int             field_oy = 0;
   int             field_w = 128;
   int             field_h = 64;
   int             quiet_cycles = 0;

   depth_tested_char_framebuffer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_response(rsp_tdata);
      end
   end

   // counts cycles with no request and no response moving; covers the clearing passes
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic fb_request_type make_request(logic [1:0] op, int x, int y, int depth,
                                                   int sym);
      fb_request_type r;
      r.op_code = op;
      r.x_pos   = 10'(x);
      r.y_pos   = 10'(y);
      r.depth   = 16'(depth);
      r.symbol  = 8'(sym);
      return r;
   endfunction

   function automatic fb_request_type random_request();
      fb_request_type r;
      int             ew, eh, col, row, pick, spot, dsel;
      ew        = (field_w > dtcf_pkg::MAX_WIDTH) ? dtcf_pkg::MAX_WIDTH : field_w;
      eh        = (field_h > dtcf_pkg::MAX_HEIGHT) ? dtcf_pkg::MAX_HEIGHT : field_h;
      r.x_pos   = 10'($urandom);
      r.y_pos   = 10'($urandom);
      r.depth   = 16'($urandom);
      r.symbol  = 8'($urandom);
      pick      = $urandom_range(99);
      if (pick < 2) begin
         r.op_code = dtcf_pkg::OP_CLEAR;
      end else if (pick < 4) begin
         r.op_code = OP_UNUSED;
      end else if (pick < 95) begin
         r.op_code = (pick < 55) ? dtcf_pkg::OP_SET : dtcf_pkg::OP_GET;
         if (ew > 0 && eh > 0) begin
            spot = $urandom_range(9);
            if (spot < 6) begin
               // small corner region so sets and gets keep meeting the same cells
               col = $urandom_range((ew < 4) ? ew - 1 : 3);
               row = $urandom_range((eh < 4) ? eh - 1 : 3);
            end else begin
               col = $urandom_range(ew - 1);
               row = $urandom_range(eh - 1);
            end
            if (spot == 9) begin
               if ($urandom_range(1)) col = $urandom_range(1) ? ew : -1;
               else row = $urandom_range(1) ? eh : -1;
            end
            r.x_pos = 10'(col - field_ox);
            r.y_pos = 10'(row - field_oy);
         end
         dsel = $urandom_range(9);
         if (dsel == 1) r.depth = 16'(-$urandom_range(256));
         else if (dsel > 1) r.depth = 16'($urandom_range(2048, 1));
      end else begin
         // noise: raw coordinates over the whole range
         r.op_code = $urandom_range(1) ? dtcf_pkg::OP_SET : dtcf_pkg::OP_GET;
      end
      return r;
   endfunction

   task automatic send_request(input fb_request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.op_code;
      req_tdata  <= {4'b0, r.symbol, r.depth, r.y_pos, r.x_pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
   endtask

   task automatic program_field(input int ox, input int oy, input int w, input int h);
      dtcf_pkg::csr_index_type regs [4];
      logic [8:0]              vals [4];
      regs = '{dtcf_pkg::CSR_ORIGIN_X, dtcf_pkg::CSR_ORIGIN_Y,
               dtcf_pkg::CSR_ACTIVE_WIDTH, dtcf_pkg::CSR_ACTIVE_HEIGHT};
      vals = '{9'(ox), 9'(oy), 9'(w), 9'(h)};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         board.write_register(regs[i], vals[i]);
      end
      csr_we   <= 1'b0;
      field_ox  = ox;
      field_oy  = oy;
      field_w   = w;
      field_h   = h;
   endtask

   task automatic run_phase(input int ox, input int oy, input int w, input int h,
                            input int idle_pct, input int stall_pct, input int count);
      wait_drained();
      program_field(ox, oy, w, h);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         send_request(random_request());
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      program_field(0, 0, 128, 64);

      // depth test on one cell: empty, farther, equal, nearer, non-positive
      send_request(make_request(dtcf_pkg::OP_GET, 0, 0, 0, 0));
      send_request(make_request(dtcf_pkg::OP_SET, 0, 0, 16'h0100, 65));
      send_request(make_request(dtcf_pkg::OP_SET, 0, 0, 16'h0200, 66));
      send_request(make_request(dtcf_pkg::OP_SET, 0, 0, 16'h0100, 67));
      send_request(make_request(dtcf_pkg::OP_SET, 0, 0, 16'h0080, 68));
      send_request(make_request(dtcf_pkg::OP_SET, 0, 0, 0, 69));
      send_request(make_request(dtcf_pkg::OP_SET, 0, 0, -32768, 70));
      send_request(make_request(dtcf_pkg::OP_GET, 0, 0, 0, 0));
      // far corner, depth and symbol extremes
      send_request(make_request(dtcf_pkg::OP_SET, 127, 63, 32767, 255));
      send_request(make_request(dtcf_pkg::OP_SET, 127, 63, 1, 0));
      send_request(make_request(dtcf_pkg::OP_GET, 127, 63, -1, 255));
      // just outside and coordinate extremes
      send_request(make_request(dtcf_pkg::OP_SET, 128, 0, 16'h0100, 90));
      send_request(make_request(dtcf_pkg::OP_GET, 128, 0, 0, 0));
      send_request(make_request(dtcf_pkg::OP_GET, 0, 64, 0, 0));
      send_request(make_request(dtcf_pkg::OP_GET, -1, 0, 0, 0));
      send_request(make_request(dtcf_pkg::OP_GET, 511, 511, 0, 0));
      send_request(make_request(dtcf_pkg::OP_SET, -512, -512, 16'h0100, 90));
      send_request(make_request(OP_UNUSED, -1, -1, -1, 255));
      send_request(make_request(dtcf_pkg::OP_CLEAR, -1, -1, -1, 255));
      send_request(make_request(dtcf_pkg::OP_GET, 0, 0, 0, 0));
      send_request(make_request(dtcf_pkg::OP_GET, 127, 63, 0, 0));

      run_phase(0, 0, 128, 64, 0, 0, 65);
      run_phase(-256, 255, 1, 1, 59, 0, 65);
      run_phase(255, -256, 255, 127, 0, 59, 65);
      run_phase(10, -3, 0, 20, 25, 25, 65);
      run_phase(-7, 12, 90, 0, 0, 0, 65);
      run_phase(3, -2, 128, 64, 59, 0, 65);
      run_phase(-100, 50, 64, 32, 25, 25, 65);

      wait_drained();
      repeat (8) @(posedge clock);
      if (board.error_count == 0 && board.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/dtcf_pkg.sv
sv/dtcf_datapath.sv
sv/dtcf_ctrl.sv
sv/depth_tested_char_framebuffer_unit.sv
bench/tb_depth_tested_char_framebuffer_unit.sv
